// File: rtl/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// shared constants, codes and types of the tty line editor
// ----------------------------------------------------------------------------
package tle_pkg;

  // line store depth, count and index widths
  localparam int LINE_CHARS = 32;
  localparam int CNT_W      = 6;
  localparam int ADDR_W     = $clog2(LINE_CHARS);

  // control characters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_NUL = 8'h00;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_END  = 2'd2,
    KIND_DROP = 2'd3
  } kind_t;

  // what the accepted character asks for
  typedef enum logic [1:0] {
    OP_EOL,
    OP_BS,
    OP_STORE,
    OP_FULL
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO1,
    ST_ECHO2,
    ST_RD,
    ST_LB,
    ST_END,
    ST_DROP
  } state_t;

  // one result transaction from the sequencer to the output register
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] len;
    logic             last;
  } res_t;

endpackage

// File: rtl/tty_line_editor_unit.sv
// ----------------------------------------------------------------------------
// tty_line_editor_unit
// canonical line editing for a serial terminal receive path
// ----------------------------------------------------------------------------
// Takes one received character per input transaction, together with a flag
// telling whether a line consumer can take a line now, and produces the echo,
// line and drop transactions it causes; the final one carries out_last. One
// character is handled at a time: in_ready is high only while the sequencer
// is idle. An ordinary character or backspace gives one echo, held by output
// stalls; CR/LF or a full store with a ready consumer walks the line store
// through its single registered read port, one stored byte per ST_RD/ST_LB
// pass, up to the saved count or a stored zero byte. The store holds
// LINE_CHARS-1 characters; line bytes stop at a stored zero byte, while the
// line end still reports the stored count plus one. A backspace on an empty
// line is consumed with no result transaction. No reset pass is needed.
// ----------------------------------------------------------------------------
module tty_line_editor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_taker_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_line_length,
  output logic       out_last
);

  // store port wiring
  logic                       ram_we;
  logic [tle_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic [tle_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  // result transaction from the sequencer
  logic          res_valid;
  logic          res_ready;
  tle_pkg::res_t res;

  // output register
  logic          out_valid_r, out_valid_nxt;
  tle_pkg::res_t out_r, out_nxt;

  tle_ram #(
    .WIDTH (8),
    .DEPTH (tle_pkg::LINE_CHARS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tle_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char_in),
    .in_taker  (in_taker_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // slot free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_r.kind;
  assign out_data_byte   = out_r.data;
  assign out_line_length = out_r.len;
  assign out_last        = out_r.last;

endmodule

// File: rtl/tle_ram.sv
// ----------------------------------------------------------------------------
// tle_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tle_seq.sv
// ----------------------------------------------------------------------------
// tle_seq
// per-character sequencer: decodes, updates the count, walks the line store
// ----------------------------------------------------------------------------
module tle_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_char,
  input  logic                       in_taker,
  output logic                       ram_we,
  output logic [tle_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata,
  output logic [tle_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [7:0]                 ram_rdata,
  output logic                       res_valid,
  output tle_pkg::res_t              res,
  input  logic                       res_ready
);

  tle_pkg::state_t                state_r, state_nxt;
  tle_pkg::op_t                   op_r, op_nxt;
  logic [7:0]                     ch_r, ch_nxt;
  logic                           rdy_r, rdy_nxt;
  logic [tle_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [tle_pkg::CNT_W-1:0]      line_cnt_r, line_cnt_nxt;
  logic [tle_pkg::ADDR_W-1:0]     idx_r, idx_nxt;
  logic                           accept;
  logic                           idx_at_end;

  assign accept     = in_valid && in_ready;
  assign idx_at_end = ({{(tle_pkg::CNT_W-tle_pkg::ADDR_W){1'b0}}, idx_r} == line_cnt_r);
  assign ram_raddr  = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tle_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    rdy_r      <= rdy_nxt;
    line_cnt_r <= line_cnt_nxt;
    idx_r      <= idx_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    ch_nxt       = ch_r;
    rdy_nxt      = rdy_r;
    cnt_nxt      = cnt_r;
    line_cnt_nxt = line_cnt_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r[tle_pkg::ADDR_W-1:0];
    ram_wdata    = in_char;
    res_valid    = 1'b0;
    res.kind     = tle_pkg::KIND_ECHO;
    res.data     = tle_pkg::CH_NUL;
    res.len      = '0;
    res.last     = 1'b0;

    case (state_r)
      tle_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          ch_nxt  = in_char;
          rdy_nxt = in_taker;
          idx_nxt = '0;
          if (in_char == tle_pkg::CH_CR || in_char == tle_pkg::CH_LF) begin
            op_nxt       = tle_pkg::OP_EOL;
            line_cnt_nxt = cnt_r;
            cnt_nxt      = '0;
            state_nxt    = tle_pkg::ST_ECHO1;
          end else if (in_char == tle_pkg::CH_BS) begin
            op_nxt = tle_pkg::OP_BS;
            // backspace on an empty line leaves the count alone and produces no result
            if (cnt_r != '0) begin
              cnt_nxt   = cnt_r - tle_pkg::CNT_W'(1);
              state_nxt = tle_pkg::ST_ECHO1;
            end
          end else if (cnt_r < tle_pkg::CNT_W'(tle_pkg::LINE_CHARS - 1)) begin
            op_nxt    = tle_pkg::OP_STORE;
            ram_we    = 1'b1;
            cnt_nxt   = cnt_r + tle_pkg::CNT_W'(1);
            state_nxt = tle_pkg::ST_ECHO1;
          end else begin
            op_nxt       = tle_pkg::OP_FULL;
            line_cnt_nxt = cnt_r;
            cnt_nxt      = '0;
            state_nxt    = tle_pkg::ST_ECHO1;
          end
        end
      end
      tle_pkg::ST_ECHO1: begin
        res_valid = 1'b1;
        res.data  = (op_r == tle_pkg::OP_EOL) ? tle_pkg::CH_CR : ch_r;
        res.last  = (op_r == tle_pkg::OP_BS) || (op_r == tle_pkg::OP_STORE);
        if (res_ready) begin
          case (op_r)
            tle_pkg::OP_EOL:  state_nxt = tle_pkg::ST_ECHO2;
            tle_pkg::OP_FULL: state_nxt = rdy_r ? tle_pkg::ST_RD : tle_pkg::ST_DROP;
            default:          state_nxt = tle_pkg::ST_IDLE;
          endcase
        end
      end
      tle_pkg::ST_ECHO2: begin
        res_valid = 1'b1;
        res.data  = tle_pkg::CH_LF;
        res.last  = !rdy_r;
        if (res_ready) begin
          state_nxt = rdy_r ? tle_pkg::ST_RD : tle_pkg::ST_IDLE;
        end
      end
      tle_pkg::ST_RD: begin
        // read address is idx_r; data shows up in ST_LB
        state_nxt = idx_at_end ? tle_pkg::ST_END : tle_pkg::ST_LB;
      end
      tle_pkg::ST_LB: begin
        if (ram_rdata == tle_pkg::CH_NUL) begin
          state_nxt = tle_pkg::ST_END;
        end else begin
          res_valid = 1'b1;
          res.kind  = tle_pkg::KIND_BYTE;
          res.data  = ram_rdata;
          if (res_ready) begin
            idx_nxt   = idx_r + tle_pkg::ADDR_W'(1);
            state_nxt = tle_pkg::ST_RD;
          end
        end
      end
      tle_pkg::ST_END: begin
        res_valid = 1'b1;
        res.kind  = tle_pkg::KIND_END;
        res.len   = line_cnt_r + tle_pkg::CNT_W'(1);
        res.last  = 1'b1;
        if (res_ready) begin
          state_nxt = tle_pkg::ST_IDLE;
        end
      end
      tle_pkg::ST_DROP: begin
        res_valid = 1'b1;
        res.kind  = tle_pkg::KIND_DROP;
        res.last  = 1'b1;
        if (res_ready) begin
          state_nxt = tle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tle_pkg::ST_IDLE;
      end
    endcase
  end

  // count never reaches the store depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < tle_pkg::CNT_W'(tle_pkg::LINE_CHARS))
    else $error("char count out of range");

  // line walk stays inside the saved line
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tle_pkg::ST_LB) |->
      ({{(tle_pkg::CNT_W-tle_pkg::ADDR_W){1'b0}}, idx_r} < line_cnt_r))
    else $error("line index beyond saved count");

  // a line end always closes the transaction group of its character
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == tle_pkg::KIND_END) |-> res.last)
    else $error("line end without last");

  // any accepted character other than a backspace keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_char != tle_pkg::CH_BS) |=> !in_ready)
    else $error("ready right after a character that produces results");

endmodule
